### rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("property violated");

// next-cycle implication, off while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("property violated");

// next-cycle implication, also checked through reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("property violated");

`endif

### rtl/core/ntss_pkg.sv
package ntss_pkg;

    localparam int POS_BITS  = 11;
    localparam int DIST_BITS = 16;
    localparam int NUM_CAND  = 4;

    // candidate slots, in the order they are weighed
    localparam int CAND_LO1 = 0;
    localparam int CAND_LO2 = 1;
    localparam int CAND_HI0 = 2;
    localparam int CAND_HI1 = 3;

    typedef enum logic {
        CMD_CLEAR  = 1'b0,
        CMD_INSERT = 1'b1
    } cmd_t;

    typedef struct packed {
        logic lt;
        logic eq;
        logic hit_lo1;
        logic hit_lo2;
        logic hit_hi0;
        logic hit_hi1;
    } cell_stat_t;

endpackage

### rtl/core/ntss_cell.sv
module ntss_cell #(
    parameter int VALUE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 capture,
    input  logic signed [VALUE_BITS-1:0]         x,
    input  logic                                 occupied,
    input  logic                                 lt_m1,
    input  logic                                 lt_m2,
    input  logic                                 lt_p1,
    input  logic                                 lt_p2,
    input  logic                                 shift,
    input  logic signed [VALUE_BITS-1:0]         ins_value,
    input  logic        [ntss_pkg::POS_BITS-1:0] ins_pos,
    input  logic signed [VALUE_BITS-1:0]         left_value,
    input  logic        [ntss_pkg::POS_BITS-1:0] left_pos,
    output ntss_pkg::cell_stat_t                 stat,
    output logic signed [VALUE_BITS-1:0]         value,
    output logic        [ntss_pkg::POS_BITS-1:0] pos
);

    logic signed [VALUE_BITS-1:0]         value_reg;
    logic signed [VALUE_BITS-1:0]         value_next;
    logic        [ntss_pkg::POS_BITS-1:0] pos_reg;
    logic        [ntss_pkg::POS_BITS-1:0] pos_next;
    logic                                 lt_reg;
    logic                                 eq_reg;
    logic                                 occ_reg;

    // cells at or above the insertion point move up by one
    always_comb
    begin
        value_next = value_reg;
        pos_next   = pos_reg;
        if (shift && !lt_reg)
        begin
            if (lt_m1)
            begin
                value_next = ins_value;
                pos_next   = ins_pos;
            end
            else
            begin
                value_next = left_value;
                pos_next   = left_pos;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        pos_reg   <= pos_next;
        if (capture)
        begin
            lt_reg  <= occupied && (value_reg < x);
            eq_reg  <= (value_reg == x);
            occ_reg <= occupied;
        end
    end

    assign stat.lt      = lt_reg;
    assign stat.eq      = eq_reg;
    assign stat.hit_lo1 = lt_reg && !lt_p1;
    assign stat.hit_lo2 = lt_reg && lt_p1 && !lt_p2;
    assign stat.hit_hi0 = occ_reg && !lt_reg && lt_m1;
    assign stat.hit_hi1 = occ_reg && !lt_reg && !lt_m1 && lt_m2;

    assign value = value_reg;
    assign pos   = pos_reg;

endmodule

### rtl/core/ntss_pick.sv
module ntss_pick #(
    parameter int VALUE_BITS = 16
) (
    input  logic signed [VALUE_BITS-1:0]          x,
    input  logic signed [VALUE_BITS-1:0]          cand_value [ntss_pkg::NUM_CAND],
    input  logic        [ntss_pkg::POS_BITS-1:0]  cand_pos   [ntss_pkg::NUM_CAND],
    input  logic                                  cand_have  [ntss_pkg::NUM_CAND],
    output logic        [ntss_pkg::POS_BITS-1:0]  nearest_pos,
    output logic        [ntss_pkg::DIST_BITS-1:0] nearest_dist,
    output logic        [ntss_pkg::POS_BITS-1:0]  second_pos,
    output logic        [ntss_pkg::DIST_BITS-1:0] second_dist
);

    always_comb
    begin
        logic                                 have1;
        logic                                 have2;
        logic        [ntss_pkg::POS_BITS-1:0] pos1;
        logic        [ntss_pkg::POS_BITS-1:0] pos2;
        logic        [VALUE_BITS:0]           d1;
        logic        [VALUE_BITS:0]           d2;
        logic signed [VALUE_BITS-1:0]         v1;
        logic signed [VALUE_BITS-1:0]         v2;
        logic signed [VALUE_BITS:0]           xe;
        logic signed [VALUE_BITS:0]           ye;
        logic signed [VALUE_BITS:0]           diff;
        logic        [VALUE_BITS:0]           d;
        have1 = 1'b0;
        have2 = 1'b0;
        pos1  = '0;
        pos2  = '0;
        d1    = '0;
        d2    = '0;
        v1    = '0;
        v2    = '0;
        xe    = {x[VALUE_BITS-1], x};
        for (int k = 0; k < ntss_pkg::NUM_CAND; k++)
        begin
            ye   = {cand_value[k][VALUE_BITS-1], cand_value[k]};
            diff = xe - ye;
            d    = diff[VALUE_BITS] ? (VALUE_BITS+1)'(-diff) : diff;
            if (cand_have[k])
            begin
                if (!have1 || d < d1 || (d == d1 && cand_value[k] < v1))
                begin
                    have2 = have1;
                    pos2  = pos1;
                    d2    = d1;
                    v2    = v1;
                    have1 = 1'b1;
                    pos1  = cand_pos[k];
                    d1    = d;
                    v1    = cand_value[k];
                end
                else if (!have2 || d < d2 || (d == d2 && cand_value[k] < v2))
                begin
                    have2 = 1'b1;
                    pos2  = cand_pos[k];
                    d2    = d;
                    v2    = cand_value[k];
                end
            end
        end
        nearest_pos  = have1 ? pos1 : '0;
        nearest_dist = have1 ? ntss_pkg::DIST_BITS'(d1) : '0;
        second_pos   = have2 ? pos2 : '0;
        second_dist  = have2 ? ntss_pkg::DIST_BITS'(d2) : '0;
    end

endmodule

### rtl/core/nearest_two_by_value_sorted_store.sv
// path: an accepted transaction passes the s1 register, the s2 candidate register and the
// output register, and can stall on result_ready; a new one is taken only when s1 is empty, as
// the cell row compares, then shifts, and the next compare has to see the shifted row
// reset: clears the entry count and all valid flags; stored cells keep whatever
// they hold, no clearing pass is run
module nearest_two_by_value_sorted_store #(
    parameter int STORE_DEPTH = 1024,
    parameter int VALUE_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  logic                                  cmd,
    input  logic        [ntss_pkg::POS_BITS-1:0]  position,
    input  logic signed [VALUE_BITS-1:0]          value,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic        [ntss_pkg::POS_BITS-1:0]  nearest_pos,
    output logic        [ntss_pkg::DIST_BITS-1:0] nearest_dist,
    output logic        [ntss_pkg::POS_BITS-1:0]  second_pos,
    output logic        [ntss_pkg::DIST_BITS-1:0] second_dist,
    output logic                                  overflow
);

    localparam int CNT_BITS  = $clog2(STORE_DEPTH + 1);
    localparam int CAND_BITS = VALUE_BITS + ntss_pkg::POS_BITS;

    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    logic                                 s1_valid_reg;
    ntss_pkg::cmd_t                       s1_cmd_reg;
    logic signed [VALUE_BITS-1:0]         s1_x_reg;
    logic        [ntss_pkg::POS_BITS-1:0] s1_pos_reg;

    logic                                 s2_valid_reg;
    logic signed [VALUE_BITS-1:0]         s2_x_reg;
    logic                                 s2_ovf_reg;
    logic signed [VALUE_BITS-1:0]         s2_value_reg [ntss_pkg::NUM_CAND];
    logic        [ntss_pkg::POS_BITS-1:0] s2_pos_reg   [ntss_pkg::NUM_CAND];
    logic                                 s2_have_reg  [ntss_pkg::NUM_CAND];

    logic                                  res_valid_reg;
    logic        [ntss_pkg::POS_BITS-1:0]  res_npos_reg;
    logic        [ntss_pkg::DIST_BITS-1:0] res_ndist_reg;
    logic        [ntss_pkg::POS_BITS-1:0]  res_spos_reg;
    logic        [ntss_pkg::DIST_BITS-1:0] res_sdist_reg;
    logic                                  res_ovf_reg;

    logic accept;
    logic s1_move;
    logic s2_move;
    logic is_insert;
    logic store_full;
    logic dup;
    logic do_shift;

    ntss_pkg::cell_stat_t                 stat       [STORE_DEPTH];
    logic signed [VALUE_BITS-1:0]         cell_value [STORE_DEPTH];
    logic        [ntss_pkg::POS_BITS-1:0] cell_pos   [STORE_DEPTH];
    logic        [STORE_DEPTH+3:0]        lt_ext;

    logic [CAND_BITS-1:0] slot_data [ntss_pkg::NUM_CAND];
    logic                 slot_have [ntss_pkg::NUM_CAND];

    logic        [ntss_pkg::POS_BITS-1:0]  pick_npos;
    logic        [ntss_pkg::DIST_BITS-1:0] pick_ndist;
    logic        [ntss_pkg::POS_BITS-1:0]  pick_spos;
    logic        [ntss_pkg::DIST_BITS-1:0] pick_sdist;

    assign item_ready = !s1_valid_reg;
    assign accept     = item_valid && item_ready;
    assign s2_move    = s2_valid_reg && (!res_valid_reg || result_ready);
    assign s1_move    = s1_valid_reg && (!s2_valid_reg || s2_move);

    // two guard bits on each side of the row
    assign lt_ext[1:0]                         = 2'b11;
    assign lt_ext[STORE_DEPTH+3:STORE_DEPTH+2] = 2'b00;

    for (genvar i = 0; i < STORE_DEPTH; i++)
    begin : g_cell
        logic signed [VALUE_BITS-1:0]         left_value;
        logic        [ntss_pkg::POS_BITS-1:0] left_pos;

        if (i == 0)
        begin : g_first
            assign left_value = s1_x_reg;
            assign left_pos   = s1_pos_reg;
        end
        else
        begin : g_rest
            assign left_value = cell_value[i-1];
            assign left_pos   = cell_pos[i-1];
        end

        assign lt_ext[i+2] = stat[i].lt;

        ntss_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk        (clk),
            .capture    (accept),
            .x          (value),
            .occupied   (CNT_BITS'(i) < count_reg),
            .lt_m1      (lt_ext[i+1]),
            .lt_m2      (lt_ext[i]),
            .lt_p1      (lt_ext[i+3]),
            .lt_p2      (lt_ext[i+4]),
            .shift      (do_shift),
            .ins_value  (s1_x_reg),
            .ins_pos    (s1_pos_reg),
            .left_value (left_value),
            .left_pos   (left_pos),
            .stat       (stat[i]),
            .value      (cell_value[i]),
            .pos        (cell_pos[i])
        );
    end

    // each slot is hit by at most one cell
    always_comb
    begin
        for (int k = 0; k < ntss_pkg::NUM_CAND; k++)
        begin
            slot_data[k] = '0;
            slot_have[k] = 1'b0;
        end
        dup = 1'b0;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (stat[i].hit_lo1)
            begin
                slot_data[ntss_pkg::CAND_LO1] |= {cell_value[i], cell_pos[i]};
                slot_have[ntss_pkg::CAND_LO1] = 1'b1;
            end
            if (stat[i].hit_lo2)
            begin
                slot_data[ntss_pkg::CAND_LO2] |= {cell_value[i], cell_pos[i]};
                slot_have[ntss_pkg::CAND_LO2] = 1'b1;
            end
            if (stat[i].hit_hi0)
            begin
                slot_data[ntss_pkg::CAND_HI0] |= {cell_value[i], cell_pos[i]};
                slot_have[ntss_pkg::CAND_HI0] = 1'b1;
                dup = dup | stat[i].eq;
            end
            if (stat[i].hit_hi1)
            begin
                slot_data[ntss_pkg::CAND_HI1] |= {cell_value[i], cell_pos[i]};
                slot_have[ntss_pkg::CAND_HI1] = 1'b1;
            end
        end
    end

    assign is_insert  = (s1_cmd_reg == ntss_pkg::CMD_INSERT);
    assign store_full = (count_reg == CNT_BITS'(STORE_DEPTH));
    assign do_shift   = s1_move && is_insert && !dup && !store_full;

    always_comb
    begin
        count_next = count_reg;
        if (s1_move)
        begin
            if (!is_insert)
            begin
                count_next = '0;
            end
            else if (do_shift)
            begin
                count_next = count_reg + CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_move)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_move)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= ntss_pkg::cmd_t'(cmd);
            s1_x_reg   <= value;
            s1_pos_reg <= position;
        end
        if (s1_move)
        begin
            s2_x_reg   <= s1_x_reg;
            s2_ovf_reg <= is_insert && !dup && store_full;
            for (int k = 0; k < ntss_pkg::NUM_CAND; k++)
            begin
                s2_value_reg[k] <= slot_data[k][CAND_BITS-1:ntss_pkg::POS_BITS];
                s2_pos_reg[k]   <= slot_data[k][ntss_pkg::POS_BITS-1:0];
                s2_have_reg[k]  <= is_insert && slot_have[k];
            end
        end
        if (s2_move)
        begin
            res_npos_reg  <= pick_npos;
            res_ndist_reg <= pick_ndist;
            res_spos_reg  <= pick_spos;
            res_sdist_reg <= pick_sdist;
            res_ovf_reg   <= s2_ovf_reg;
        end
    end

    ntss_pick #(
        .VALUE_BITS (VALUE_BITS)
    ) u_pick (
        .x            (s2_x_reg),
        .cand_value   (s2_value_reg),
        .cand_pos     (s2_pos_reg),
        .cand_have    (s2_have_reg),
        .nearest_pos  (pick_npos),
        .nearest_dist (pick_ndist),
        .second_pos   (pick_spos),
        .second_dist  (pick_sdist)
    );

    assign result_valid = res_valid_reg;
    assign nearest_pos  = res_npos_reg;
    assign nearest_dist = res_ndist_reg;
    assign second_pos   = res_spos_reg;
    assign second_dist  = res_sdist_reg;
    assign overflow     = res_ovf_reg;

endmodule

### rtl/core/ntss_checker.sv
`include "assert_macros.svh"

module ntss_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  item_valid,
    input logic                                  item_ready,
    input logic                                  result_valid,
    input logic                                  result_ready,
    input logic        [ntss_pkg::POS_BITS-1:0]  nearest_pos,
    input logic        [ntss_pkg::DIST_BITS-1:0] nearest_dist
);

    // one transaction in the compare stage at a time
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, item_valid && item_ready, !item_ready)

    // a stalled result stays put
    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(nearest_pos) && $stable(nearest_dist))

    // nothing comes out of reset
    `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !result_valid)

    // the compare stage is free right out of reset, when nothing at all is pending
    `ASSERT_SAME(a_idle_ready, clk, rst_n, $past(!rst_n), item_ready)

endmodule

bind nearest_two_by_value_sorted_store ntss_checker u_checker (.*);

### tb/sv/tb_nearest_two_by_value_sorted_store.sv
module tb_nearest_two_by_value_sorted_store;

    localparam int DEPTH      = 1024;
    localparam int VAL_BITS   = 16;
    localparam int POS_TOP    = 1024;
    localparam int ITEM_GOAL  = 1850;
    localparam int CALM_FROM  = 1700;
    localparam int HOLD_LEN   = 80;

    typedef struct packed {
        logic [ntss_pkg::POS_BITS-1:0]  nearest_pos;
        logic [ntss_pkg::DIST_BITS-1:0] nearest_dist;
        logic [ntss_pkg::POS_BITS-1:0]  second_pos;
        logic [ntss_pkg::DIST_BITS-1:0] second_dist;
        logic                           overflow;
    } answer_t;

    class neighbor_tracker;
        int      ladder_val [DEPTH];
        int      ladder_pos [DEPTH];
        int      fill = 0;
        answer_t answers_due[$];
        int      errors = 0;

        bit      have1, have2;
        int      pos1, pos2, d1, d2, v1, v2;

        function void weigh(int x, int idx);
            int y;
            int d;
            y = ladder_val[idx];
            d = x - y;
            if (d < 0)
                d = -d;
            if (!have1 || d < d1 || (d == d1 && y < v1))
            begin
                have2 = have1;
                pos2  = pos1;
                d2    = d1;
                v2    = v1;
                have1 = 1'b1;
                pos1  = ladder_pos[idx];
                d1    = d;
                v1    = y;
            end
            else if (!have2 || d < d2 || (d == d2 && y < v2))
            begin
                have2 = 1'b1;
                pos2  = ladder_pos[idx];
                d2    = d;
                v2    = y;
            end
        endfunction

        function void take_element(logic c, logic [ntss_pkg::POS_BITS-1:0] p,
                                   logic signed [VAL_BITS-1:0] v);
            int      x;
            int      lb;
            int      n;
            answer_t a;
            a = '0;
            if (c == ntss_pkg::CMD_CLEAR)
            begin
                fill = 0;
                answers_due.push_back(a);
                return;
            end
            x     = v;
            n     = fill;
            lb    = 0;
            have1 = 1'b0;
            have2 = 1'b0;
            while (lb < n && ladder_val[lb] < x)
                lb++;
            if (lb >= 1)
                weigh(x, lb - 1);
            if (lb >= 2)
                weigh(x, lb - 2);
            if (lb < n)
                weigh(x, lb);
            if (lb + 1 < n)
                weigh(x, lb + 1);
            if (!(lb < n && ladder_val[lb] == x))
            begin
                if (n >= DEPTH)
                    a.overflow = 1'b1;
                else
                begin
                    for (int i = n; i > lb; i--)
                    begin
                        ladder_val[i] = ladder_val[i-1];
                        ladder_pos[i] = ladder_pos[i-1];
                    end
                    ladder_val[lb] = x;
                    ladder_pos[lb] = p;
                    fill = n + 1;
                end
            end
            if (have1)
            begin
                a.nearest_pos  = pos1[ntss_pkg::POS_BITS-1:0];
                a.nearest_dist = d1[ntss_pkg::DIST_BITS-1:0];
            end
            if (have2)
            begin
                a.second_pos  = pos2[ntss_pkg::POS_BITS-1:0];
                a.second_dist = d2[ntss_pkg::DIST_BITS-1:0];
            end
            answers_due.push_back(a);
        endfunction

        function void check_answer(logic [ntss_pkg::POS_BITS-1:0] np,
                                   logic [ntss_pkg::DIST_BITS-1:0] nd,
                                   logic [ntss_pkg::POS_BITS-1:0] sp,
                                   logic [ntss_pkg::DIST_BITS-1:0] sd,
                                   logic ov);
            answer_t want;
            if (answers_due.size() == 0)
            begin
                $error("result transaction with nothing pending");
                errors++;
                return;
            end
            want = answers_due.pop_front();
            if (np !== want.nearest_pos)
            begin
                $error("nearest_pos expected %0d actual %0d", want.nearest_pos, np);
                errors++;
            end
            if (nd !== want.nearest_dist)
            begin
                $error("nearest_dist expected %0d actual %0d", want.nearest_dist, nd);
                errors++;
            end
            if (sp !== want.second_pos)
            begin
                $error("second_pos expected %0d actual %0d", want.second_pos, sp);
                errors++;
            end
            if (sd !== want.second_dist)
            begin
                $error("second_dist expected %0d actual %0d", want.second_dist, sd);
                errors++;
            end
            if (ov !== want.overflow)
            begin
                $error("overflow expected %0d actual %0d", want.overflow, ov);
                errors++;
            end
        endfunction

        function int pending();
            return answers_due.size();
        endfunction

        function void flag_leftovers();
            if (answers_due.size() != 0)
            begin
                $error("%0d results never arrived", answers_due.size());
                errors++;
            end
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           item_valid = 1'b0;
    logic                           item_ready;
    logic                           cmd = ntss_pkg::CMD_CLEAR;
    logic [ntss_pkg::POS_BITS-1:0]  position = '0;
    logic signed [VAL_BITS-1:0]     value = '0;
    logic                           result_valid;
    logic                           result_ready = 1'b0;
    logic [ntss_pkg::POS_BITS-1:0]  nearest_pos;
    logic [ntss_pkg::DIST_BITS-1:0] nearest_dist;
    logic [ntss_pkg::POS_BITS-1:0]  second_pos;
    logic [ntss_pkg::DIST_BITS-1:0] second_dist;
    logic                           overflow;

    neighbor_tracker sb;
    int              sent = 0;
    int              gap_rate = 0;
    bit              calm = 1'b0;

    nearest_two_by_value_sorted_store u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .cmd          (cmd),
        .position     (position),
        .value        (value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .nearest_pos  (nearest_pos),
        .nearest_dist (nearest_dist),
        .second_pos   (second_pos),
        .second_dist  (second_dist),
        .overflow     (overflow)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("tb_nearest_two_by_value_sorted_store: errors");
        $finish;
    end

    task automatic send_item(input logic c, input int p, input int v);
        int gap;
        gap = 0;
        if (sent % 100 == 0)
        begin
            case ($urandom_range(0, 2))
                0: gap_rate = 0;
                1: gap_rate = 1;
                default: gap_rate = 3;
            endcase
        end
        calm = (sent >= CALM_FROM);
        if (!calm && gap_rate != 0 && $urandom_range(0, 9) < gap_rate)
            gap = $urandom_range(1, 4);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        cmd        <= c;
        position   <= p[ntss_pkg::POS_BITS-1:0];
        value      <= v[VAL_BITS-1:0];
        do
            @(posedge clk);
        while (!item_ready);
        sb.take_element(c, p[ntss_pkg::POS_BITS-1:0], v[VAL_BITS-1:0]);
        sent++;
    endtask

    function automatic int pick_value(int mode);
        case (mode)
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: return int'($urandom_range(0, 16)) - 8;
            2:
            begin
                case ($urandom_range(0, 5))
                    0: return -32768;
                    1: return 32767;
                    2: return -32767;
                    3: return 32766;
                    default: return int'($urandom_range(0, 65535)) - 32768;
                endcase
            end
            default: return int'($urandom_range(0, 600)) - 300;
        endcase
    endfunction

    // clear, then a run of elements at descending positions, with some noise mixed in
    task automatic run_sequence();
        int len;
        int mode;
        int p;
        send_item(ntss_pkg::CMD_CLEAR, $urandom_range(0, POS_TOP), pick_value(0));
        len  = $urandom_range(3, 60);
        mode = $urandom_range(0, 3);
        p    = ($urandom_range(0, 1) == 0) ? POS_TOP : $urandom_range(0, POS_TOP);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(1'($urandom_range(0, 1)), $urandom_range(0, POS_TOP),
                          pick_value(0));
            else
                send_item(ntss_pkg::CMD_INSERT, p, pick_value(mode));
            p = (p == 0) ? POS_TOP : p - 1;
        end
    endtask

    initial
    begin
        int p;
        int guard;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(ntss_pkg::CMD_CLEAR, 1024, -1);
        send_item(ntss_pkg::CMD_INSERT, 1024, 0);
        send_item(ntss_pkg::CMD_INSERT, 1023, 32767);
        send_item(ntss_pkg::CMD_INSERT, 1022, -32768);
        send_item(ntss_pkg::CMD_INSERT, 0, 100);
        send_item(ntss_pkg::CMD_INSERT, 1021, 100);
        send_item(ntss_pkg::CMD_INSERT, 1020, 50);
        send_item(ntss_pkg::CMD_INSERT, 682, 21845);
        send_item(ntss_pkg::CMD_INSERT, 341, -21846);
        send_item(ntss_pkg::CMD_INSERT, 1019, -1);
        send_item(ntss_pkg::CMD_INSERT, 1018, 1);
        send_item(ntss_pkg::CMD_INSERT, 1017, 75);
        send_item(ntss_pkg::CMD_CLEAR, 0, 0);
        send_item(ntss_pkg::CMD_INSERT, 5, 7);
        send_item(ntss_pkg::CMD_INSERT, 4, 7);
        send_item(ntss_pkg::CMD_INSERT, 3, -32768);
        send_item(ntss_pkg::CMD_INSERT, 2, 32767);
        send_item(ntss_pkg::CMD_CLEAR, 1023, 32767);

        while (sent < 400)
            run_sequence();

        // fill the store to the top, then push past it
        send_item(ntss_pkg::CMD_CLEAR, 0, 0);
        p = POS_TOP;
        while (sb.fill < DEPTH)
        begin
            send_item(ntss_pkg::CMD_INSERT, p, pick_value(0));
            p = (p == 0) ? POS_TOP : p - 1;
        end
        repeat (40)
        begin
            send_item(ntss_pkg::CMD_INSERT, p, pick_value($urandom_range(0, 2)));
            p = (p == 0) ? POS_TOP : p - 1;
        end

        while (sent < ITEM_GOAL)
            run_sequence();
        item_valid <= 1'b0;

        guard = 0;
        while (sb.pending() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        sb.flag_leftovers();
        if (sb.errors == 0)
            $display("tb_nearest_two_by_value_sorted_store: clean");
        else
            $display("tb_nearest_two_by_value_sorted_store: errors");
        $finish;
    end

    initial
    begin
        int idle_left;
        int hold_left;
        int cyc;
        int got;
        int next_hold;
        int stall_rate;
        idle_left  = 0;
        hold_left  = 0;
        cyc        = 0;
        got        = 0;
        next_hold  = 300;
        stall_rate = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (result_valid && result_ready)
            begin
                sb.check_answer(nearest_pos, nearest_dist, second_pos, second_dist, overflow);
                got++;
            end
            if (cyc % 128 == 0)
                stall_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
            // long hold-off so the block backs up into its input
            if (hold_left == 0 && got >= next_hold && !calm)
            begin
                hold_left = HOLD_LEN;
                next_hold = next_hold + 1000;
            end
            if (hold_left > 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else if (idle_left > 0)
            begin
                result_ready <= 1'b0;
                idle_left--;
            end
            else if (!calm && stall_rate != 0 && $urandom_range(0, 9) < stall_rate)
            begin
                result_ready <= 1'b0;
                idle_left = $urandom_range(1, 4) - 1;
            end
            else
                result_ready <= 1'b1;
        end
    end

endmodule

### nearest_two_by_value_sorted_store.f
+incdir+rtl/core
rtl/core/ntss_pkg.sv
rtl/core/ntss_cell.sv
rtl/core/ntss_pick.sv
rtl/core/nearest_two_by_value_sorted_store.sv
rtl/core/ntss_checker.sv
tb/sv/tb_nearest_two_by_value_sorted_store.sv
